// File: src/assert_macros.svh
// Concurrent assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/llsu_pkg.sv
// Types, constants and decode helpers of the local memory load/store unit.
package llsu_pkg;

    localparam int LOCAL_DEPTH = 1024;
    localparam int LOCAL_AW    = $clog2(LOCAL_DEPTH);
    localparam int LANES       = 4;
    localparam int LANE_BITS   = $clog2(LANES);
    localparam int BANK_AW     = LOCAL_AW - LANE_BITS;
    localparam int BANK_DEPTH  = LOCAL_DEPTH / LANES;

    localparam logic [7:0] ZERO_REG = 8'd255;

    localparam logic [2:0] SZ_U8   = 3'd0;
    localparam logic [2:0] SZ_S8   = 3'd1;
    localparam logic [2:0] SZ_U16  = 3'd2;
    localparam logic [2:0] SZ_S16  = 3'd3;
    localparam logic [2:0] SZ_B32  = 3'd4;
    localparam logic [2:0] SZ_B64  = 3'd5;
    localparam logic [2:0] SZ_B128 = 3'd6;
    localparam logic [2:0] SZ_BAD  = 3'd7;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SIZE  = 2'd1,
        ST_UNALIGNED = 2'd2
    } t_status;

    typedef logic [LANES-1:0][31:0] t_lane_words;

    typedef struct packed {
        logic        operation;
        logic [63:0] instruction;
        logic [31:0] base_value;
        logic [31:0] store_word0;
        logic [31:0] store_word1;
        logic [31:0] store_word2;
        logic [31:0] store_word3;
    } t_in_beat;

    typedef struct packed {
        t_status     status;
        logic [7:0]  dest_register;
        logic [2:0]  word_count;
        logic [31:0] load_word0;
        logic [31:0] load_word1;
        logic [31:0] load_word2;
        logic [31:0] load_word3;
    } t_out_beat;

    // Decoded access held for the access and merge cycles.
    typedef struct packed {
        logic                store;
        logic [2:0]          size;
        t_status             status;
        logic [7:0]          reg_idx;
        logic [LOCAL_AW-1:0] widx;
        logic [1:0]          off_lo;
        logic [2:0]          count;
        t_lane_words         src;
    } t_req;

    typedef struct packed {
        logic               rd;
        logic               wr;
        logic [BANK_AW-1:0] addr;
        logic [31:0]        wdata;
    } t_lane_req;

    function automatic logic [2:0] words_of_size(input logic [2:0] size);
        logic [2:0] n;
        unique case (size)
            SZ_B64:  n = 3'd2;
            SZ_B128: n = 3'd4;
            default: n = 3'd1;
        endcase
        return n;
    endfunction

endpackage

// File: src/llsu_lane.sv
// One memory bank lane: holds every word whose index has this lane's low bits.
module llsu_lane (
    input  logic              i_clk,
    input  llsu_pkg::t_lane_req i_req,
    output logic [31:0]       o_rdata
);
    import llsu_pkg::*;

    logic [31:0] r_mem [BANK_DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/llsu_merge.sv
// Merge stage: aligns lane read data into the result beat and builds the sub-word store word.
module llsu_merge (
    input  llsu_pkg::t_req        i_req,
    input  llsu_pkg::t_lane_words i_rdata,
    output llsu_pkg::t_out_beat   o_beat,
    output logic [31:0]           o_rmw_word
);
    import llsu_pkg::*;

    logic [1:0]  w_lo;
    logic [31:0] base_word;
    logic [7:0]  byte_val;
    logic [15:0] half_val;
    logic        sub;
    t_lane_words ld;

    always_comb begin
        w_lo      = i_req.widx[LANE_BITS-1:0];
        base_word = i_rdata[w_lo];
        sub       = (i_req.size <= SZ_S16);
        byte_val  = base_word[{i_req.off_lo, 3'b000} +: 8];
        half_val  = base_word[{i_req.off_lo[1], 4'b0000} +: 16];

        o_rmw_word = base_word;
        if (i_req.size <= SZ_S8) begin
            o_rmw_word[{i_req.off_lo, 3'b000} +: 8] = i_req.src[0][7:0];
        end else begin
            o_rmw_word[{i_req.off_lo[1], 4'b0000} +: 16] = i_req.src[0][15:0];
        end

        ld = '0;
        o_beat = '0;
        o_beat.status = i_req.status;
        if (i_req.status == ST_OK && !i_req.store) begin
            o_beat.dest_register = i_req.reg_idx;
            o_beat.word_count    = i_req.count;
            if (sub) begin
                if (i_req.size <= SZ_S8) begin
                    ld[0] = {{24{i_req.size[0] & byte_val[7]}}, byte_val};
                end else begin
                    ld[0] = {{16{i_req.size[0] & half_val[15]}}, half_val};
                end
            end else begin
                for (int i = 0; i < LANES; i++) begin
                    if (i < int'(i_req.count)) begin
                        ld[i] = i_rdata[w_lo + LANE_BITS'(i)];
                    end
                end
            end
        end
        o_beat.load_word0 = ld[0];
        o_beat.load_word1 = ld[1];
        o_beat.load_word2 = ld[2];
        o_beat.load_word3 = ld[3];
    end

endmodule

// File: src/local_memory_load_store_unit.sv
// Local memory load/store unit: four banked word lanes, decode, access and merge stages.
// A result passes the access and merge states into the output register; merge holds it
// while the output stalls. A new access is taken in idle, or in merge once the output is
// free; a sub-word store reads its word in access and writes it back in merge.
// Reset clears the sequencer and the output valid; memory contents stay undefined
// until written, with no clearing pass.
module local_memory_load_store_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  llsu_pkg::t_in_beat i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output llsu_pkg::t_out_beat o_out_beat
);
    import llsu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_ACCESS = 3'b010,
        S_MERGE  = 3'b100
    } t_state;

    t_state      r_state, n_state;
    t_req        r_req, n_req;
    logic        r_out_valid, n_out_valid;
    t_out_beat   r_out_beat;

    logic        accept, out_free;
    logic [63:0] insn;
    logic [23:0] imm;
    logic [31:0] off;
    logic [1:0]  w_lo;
    logic        sub;

    t_lane_req   lane_req [LANES];
    t_lane_words lane_rdata;
    t_out_beat   merge_beat;
    logic [31:0] rmw_word;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_MERGE) && out_free);
    assign accept     = i_in_valid && o_in_ready;

    // Decode at accept.
    always_comb begin
        insn = i_in_beat.instruction;
        imm  = insn[43:20];
        if (insn[15:8] == ZERO_REG) begin
            off = {8'd0, imm};
        end else begin
            off = i_in_beat.base_value + {{8{imm[23]}}, imm};
        end

        n_req.store   = i_in_beat.operation;
        n_req.size    = insn[50:48];
        n_req.reg_idx = insn[7:0];
        n_req.widx    = off[LOCAL_AW+1:2];
        n_req.off_lo  = off[1:0];
        n_req.count   = words_of_size(insn[50:48]);
        n_req.src     = {i_in_beat.store_word3, i_in_beat.store_word2,
                         i_in_beat.store_word1, i_in_beat.store_word0};
        priority if (insn[50:48] == SZ_BAD) begin
            n_req.status = ST_BAD_SIZE;
        end else if ((insn[50:48] == SZ_B64 && insn[0]) ||
                     (insn[50:48] == SZ_B128 && insn[1:0] != 2'b00)) begin
            n_req.status = ST_UNALIGNED;
        end else begin
            n_req.status = ST_OK;
        end
    end

    // Lane requests.
    always_comb begin
        logic [LANE_BITS-1:0] k_idx;
        logic [LANE_BITS-1:0] i_idx;
        logic                 active;
        logic                 carry;
        w_lo = r_req.widx[LANE_BITS-1:0];
        sub  = (r_req.size <= SZ_S16);
        for (int k = 0; k < LANES; k++) begin
            k_idx  = LANE_BITS'(k);
            i_idx  = k_idx - w_lo;
            active = (r_req.status == ST_OK) && ({1'b0, i_idx} < r_req.count);
            carry  = (k_idx < w_lo);
            lane_req[k].addr  = r_req.widx[LOCAL_AW-1:LANE_BITS] + BANK_AW'(carry);
            lane_req[k].rd    = (r_state == S_ACCESS) && active && (!r_req.store || sub);
            lane_req[k].wr    = ((r_state == S_ACCESS) && active && r_req.store && !sub) ||
                                ((r_state == S_MERGE) && (r_req.status == ST_OK) &&
                                 r_req.store && sub && (k_idx == w_lo));
            lane_req[k].wdata = (r_state == S_MERGE) ? rmw_word : r_req.src[i_idx];
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        llsu_lane u_lane (
            .i_clk   (i_clk),
            .i_req   (lane_req[g]),
            .o_rdata (lane_rdata[g])
        );
    end

    llsu_merge u_merge (
        .i_req      (r_req),
        .i_rdata    (lane_rdata),
        .o_beat     (merge_beat),
        .o_rmw_word (rmw_word)
    );

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_ACCESS;
                end
            end
            S_ACCESS: begin
                n_state = S_MERGE;
            end
            S_MERGE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = accept ? S_ACCESS : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= n_req;
        end
        if (r_state == S_MERGE && out_free) begin
            r_out_beat <= merge_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

// File: src/llsu_checker.sv
// Port-level checker for the local memory load/store unit, bound to the top level.
`include "assert_macros.svh"

module llsu_port_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input llsu_pkg::t_in_beat  i_in_beat,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input llsu_pkg::t_out_beat o_out_beat
);
    import llsu_pkg::*;

    logic in_seen;
    assign in_seen = i_in_valid && o_in_ready && (i_in_beat.operation || !i_in_beat.operation);

    `ASSERT_NEXT(a_in_gap, i_clk, i_rst_n, in_seen, !o_in_ready, "ready right after accept")
    `ASSERT_IMPLY(a_err_empty, i_clk, i_rst_n, o_out_valid && o_out_beat.status != ST_OK, o_out_beat.word_count == 3'd0 && o_out_beat.dest_register == 8'd0, "error beat carries load data")
    `ASSERT_IMPLY(a_count_code, i_clk, i_rst_n, o_out_valid, o_out_beat.word_count == 3'd0 || o_out_beat.word_count == 3'd1 || o_out_beat.word_count == 3'd2 || o_out_beat.word_count == 3'd4, "bad word count")
    `ASSERT_IMPLY(a_tail_zero, i_clk, i_rst_n, o_out_valid && o_out_beat.word_count == 3'd1, o_out_beat.load_word1 == 32'd0 && o_out_beat.load_word2 == 32'd0 && o_out_beat.load_word3 == 32'd0, "words past count not zero")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_beat), "stalled result beat changed")

endmodule

bind local_memory_load_store_unit llsu_port_checker u_llsu_checker (.*);

// File: bench/llsu_checker.sv
// Watches both channels, mirrors local memory, predicts each result beat and compares it.
module llsu_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  llsu_pkg::t_in_beat  i_in_beat,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  llsu_pkg::t_out_beat i_out_beat,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);
    import llsu_pkg::*;

    logic [31:0] local_mirror [LOCAL_DEPTH];
    t_out_beat   access_results_q [$];
    int          fail_count;
    int          pending_n;
    int          checked_n;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_n;
    assign o_checked    = checked_n;

    initial begin
        foreach (local_mirror[k]) begin
            local_mirror[k] = '0;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch, got %h want %h", $time, what, got, want);
        fail_count++;
    endtask

    // Applies one access to the mirror and returns the beat it must produce.
    function automatic t_out_beat predict_access(input t_in_beat b);
        t_out_beat           r;
        logic                is_store;
        logic [7:0]          rg;
        logic [23:0]         imm;
        logic [2:0]          sz;
        logic [31:0]         off;
        logic [31:0]         mask;
        logic [31:0]         lane;
        logic [LOCAL_AW-1:0] idx;
        logic [LOCAL_AW-1:0] a;
        logic [3:0][31:0]    src;
        logic [3:0][31:0]    ld;
        int                  n;
        int                  sh;
        int                  k;
        is_store = b.operation;
        rg       = b.instruction[7:0];
        imm      = b.instruction[43:20];
        sz       = b.instruction[50:48];
        src      = {b.store_word3, b.store_word2, b.store_word1, b.store_word0};
        ld       = '0;
        r        = '0;
        if (b.instruction[15:8] == ZERO_REG) begin
            off = {8'd0, imm};
        end else begin
            off = b.base_value + {{8{imm[23]}}, imm};
        end
        idx = off[LOCAL_AW+1:2];
        if (sz == SZ_BAD) begin
            r.status = ST_BAD_SIZE;
        end else if (sz <= SZ_S16) begin
            sh   = (sz <= SZ_S8) ? off[1:0] * 8 : off[1] * 16;
            mask = ((sz <= SZ_S8) ? 32'h0000_00FF : 32'h0000_FFFF) << sh;
            if (is_store) begin
                local_mirror[idx] = (local_mirror[idx] & ~mask) | ((src[0] << sh) & mask);
            end else begin
                lane = (local_mirror[idx] & mask) >> sh;
                if (sz == SZ_S8 && lane[7])
                    lane |= 32'hFFFF_FF00;
                if (sz == SZ_S16 && lane[15])
                    lane |= 32'hFFFF_0000;
                ld[0]           = lane;
                r.word_count    = 3'd1;
                r.dest_register = rg;
            end
        end else begin
            n = (sz == SZ_B32) ? 1 : (sz == SZ_B64) ? 2 : 4;
            if ((rg & (n - 1)) != 0) begin
                r.status = ST_UNALIGNED;
            end else begin
                for (k = 0; k < n; k++) begin
                    a = idx + LOCAL_AW'(k);
                    if (is_store)
                        local_mirror[a] = src[k];
                    else
                        ld[k] = local_mirror[a];
                end
                if (!is_store) begin
                    r.word_count    = 3'(n);
                    r.dest_register = rg;
                end
            end
        end
        r.load_word0 = ld[0];
        r.load_word1 = ld[1];
        r.load_word2 = ld[2];
        r.load_word3 = ld[3];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                access_results_q.push_back(predict_access(i_in_beat));
            if (i_out_valid && i_out_ready) begin
                checked_n++;
                if (access_results_q.size() == 0) begin
                    report_mismatch("unexpected result", 32'd0, 32'd0);
                end else begin
                    want = access_results_q.pop_front();
                    if (i_out_beat.status !== want.status)
                        report_mismatch("status", 32'(i_out_beat.status),
                                        32'(want.status));
                    if (i_out_beat.dest_register !== want.dest_register)
                        report_mismatch("dest_register", 32'(i_out_beat.dest_register),
                                        32'(want.dest_register));
                    if (i_out_beat.word_count !== want.word_count)
                        report_mismatch("word_count", 32'(i_out_beat.word_count),
                                        32'(want.word_count));
                    if (i_out_beat.load_word0 !== want.load_word0)
                        report_mismatch("load_word0", i_out_beat.load_word0, want.load_word0);
                    if (i_out_beat.load_word1 !== want.load_word1)
                        report_mismatch("load_word1", i_out_beat.load_word1, want.load_word1);
                    if (i_out_beat.load_word2 !== want.load_word2)
                        report_mismatch("load_word2", i_out_beat.load_word2, want.load_word2);
                    if (i_out_beat.load_word3 !== want.load_word3)
                        report_mismatch("load_word3", i_out_beat.load_word3, want.load_word3);
                end
            end
        end
        pending_n = access_results_q.size();
    end

endmodule

// File: bench/tb_local_memory_load_store_unit.sv
// Top of the load/store unit bench: clock, reset, access stimulus, result stalls and verdict.
module tb_local_memory_load_store_unit;
    import llsu_pkg::*;

    localparam logic OP_LOAD      = 1'b0;
    localparam logic OP_STORE     = 1'b1;
    localparam int   RANDOM_ITEMS = 1950;

    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_MOSTLY,
        RX_PERIODIC
    } t_rx_mode;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_beat  i_in_beat   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_beat o_out_beat;

    int fail_count;
    int pending;
    int checked;

    bit written [LOCAL_DEPTH];
    int n_sent;
    int n_loads;
    int n_stores;
    int n_bad_size;
    int n_unaligned;

    local_memory_load_store_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

    llsu_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_beat    (i_in_beat),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_beat   (o_out_beat),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_in_beat make_access(input logic op, input logic [2:0] sz,
                                             input logic [7:0] rg, input logic [7:0] oreg,
                                             input logic [23:0] imm, input logic [31:0] base,
                                             input logic [31:0] w0, input logic [31:0] w1,
                                             input logic [31:0] w2, input logic [31:0] w3);
        t_in_beat b;
        b.operation          = op;
        b.instruction        = {$urandom, $urandom};
        b.instruction[7:0]   = rg;
        b.instruction[15:8]  = oreg;
        b.instruction[43:20] = imm;
        b.instruction[50:48] = sz;
        b.base_value         = base;
        b.store_word0        = w0;
        b.store_word1        = w1;
        b.store_word2        = w2;
        b.store_word3        = w3;
        return b;
    endfunction

    function automatic t_in_beat load_access(input logic [2:0] sz, input logic [7:0] rg,
                                             input logic [7:0] oreg, input logic [23:0] imm,
                                             input logic [31:0] base);
        return make_access(OP_LOAD, sz, rg, oreg, imm, base,
                           $urandom, $urandom, $urandom, $urandom);
    endfunction

    function automatic t_in_beat random_access();
        logic [2:0]          sz;
        logic [7:0]          rg;
        logic [23:0]         imm;
        logic [31:0]         off;
        logic [LOCAL_AW-1:0] idx;
        logic                op;
        int                  pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            sz = 3'($urandom_range(SZ_U8, SZ_S16));
        else if (pick < 60)
            sz = SZ_B32;
        else if (pick < 75)
            sz = SZ_B64;
        else if (pick < 93)
            sz = SZ_B128;
        else
            sz = SZ_BAD;
        rg = 8'($urandom);
        if ($urandom_range(0, 9) != 0) begin
            if (sz == SZ_B64)
                rg[0] = 1'b0;
            if (sz == SZ_B128)
                rg[1:0] = 2'b00;
        end
        // half the accesses hit a small window that wraps past the top word
        if ($urandom_range(0, 1))
            idx = LOCAL_AW'($urandom_range(LOCAL_DEPTH - 16, LOCAL_DEPTH + 31));
        else
            idx = LOCAL_AW'($urandom);
        off                  = $urandom;
        off[LOCAL_AW+1:2]    = idx;
        imm                  = 24'($urandom);
        op                   = $urandom_range(0, 1) ? OP_STORE : OP_LOAD;
        if ($urandom_range(0, 3) == 0)
            return make_access(op, sz, rg, ZERO_REG, off[23:0], $urandom,
                               $urandom, $urandom, $urandom, $urandom);
        return make_access(op, sz, rg, 8'($urandom_range(0, 254)), imm,
                           off - {{8{imm[23]}}, imm}, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // Issues and tallies one access; one that would read unwritten words becomes a quad store over them.
    task automatic issue_access(input t_in_beat b);
        logic [2:0]          sz;
        logic [7:0]          rg;
        logic [23:0]         imm;
        logic [31:0]         off;
        logic [LOCAL_AW-1:0] idx;
        logic [LOCAL_AW-1:0] a;
        bit                  ok;
        bit                  fill;
        int                  n;
        int                  k;
        sz  = b.instruction[50:48];
        rg  = b.instruction[7:0];
        imm = b.instruction[43:20];
        if (b.instruction[15:8] == ZERO_REG)
            off = {8'd0, imm};
        else
            off = b.base_value + {{8{imm[23]}}, imm};
        idx  = off[LOCAL_AW+1:2];
        n    = (sz == SZ_B64) ? 2 : (sz == SZ_B128) ? 4 : 1;
        ok   = (sz != SZ_BAD) && ((rg & (n - 1)) == 0);
        fill = 1'b0;
        if (ok && (b.operation == OP_LOAD || sz <= SZ_S16)) begin
            for (k = 0; k < n; k++) begin
                a = idx + LOCAL_AW'(k);
                if (!written[a])
                    fill = 1'b1;
            end
        end
        if (fill) begin
            b.operation          = OP_STORE;
            b.instruction[50:48] = SZ_B128;
            b.instruction[1:0]   = 2'b00;
            n                    = 4;
        end
        if (!ok) begin
            if (sz == SZ_BAD)
                n_bad_size++;
            else
                n_unaligned++;
        end else if (b.operation == OP_STORE) begin
            n_stores++;
            for (k = 0; k < n; k++) begin
                a = idx + LOCAL_AW'(k);
                written[a] = 1'b1;
            end
        end else begin
            n_loads++;
        end
        n_sent++;
        i_in_beat  = b;
        i_in_valid = 1'b1;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // Result side: steady, random and periodic stretches, now and then a long hold-off.
    initial begin
        t_rx_mode mode;
        int       seg;
        int       k;
        seg = 0;
        k   = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (seg == 2 || $urandom_range(0, 24) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(150, 300))
                    @(negedge i_clk);
            end else begin
                mode = t_rx_mode'($urandom_range(RX_STEADY, RX_PERIODIC));
                repeat ($urandom_range(20, 200)) begin
                    case (mode)
                        RX_STEADY:   i_out_ready = 1'b1;
                        RX_COIN:     i_out_ready = 1'($urandom_range(0, 1));
                        RX_MOSTLY:   i_out_ready = ($urandom_range(0, 7) != 0);
                        RX_PERIODIC: i_out_ready = (k % 4 == 0);
                        default:     i_out_ready = 1'b1;
                    endcase
                    k++;
                    @(negedge i_clk);
                end
            end
            seg++;
        end
    end

    initial begin
        int next_drain;
        int n_written;
        int k;
        repeat (11)
            @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // quad stores, the second wrapping past the top word, then loads that read them back
        issue_access(make_access(OP_STORE, SZ_B128, 8'd0, ZERO_REG, 24'h000000, $urandom,
                                 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        issue_access(make_access(OP_STORE, SZ_B128, 8'd4, ZERO_REG, 24'h000FF8, $urandom,
                                 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0123_4567, 32'h89AB_CDEF));
        issue_access(load_access(SZ_B128, 8'd8, ZERO_REG, 24'hFFFFF8, $urandom));
        issue_access(load_access(SZ_B64, 8'd254, ZERO_REG, 24'hFFFFFC, $urandom));
        issue_access(load_access(SZ_B32, 8'd255, 8'd0, 24'h000001, 32'hFFFF_FFFF));
        // lane extracts with the sign bit set
        issue_access(load_access(SZ_U8, 8'd1, ZERO_REG, 24'h000FFB, $urandom));
        issue_access(load_access(SZ_S8, 8'd2, ZERO_REG, 24'h000FFB, $urandom));
        issue_access(load_access(SZ_U16, 8'd3, ZERO_REG, 24'h000FFA, $urandom));
        issue_access(load_access(SZ_S16, 8'd4, ZERO_REG, 24'h000FFA, $urandom));
        issue_access(load_access(SZ_S16, 8'd5, ZERO_REG, 24'h00000C, $urandom));
        // lane inserts
        issue_access(make_access(OP_STORE, SZ_U8, 8'd6, ZERO_REG, 24'h00000D, $urandom,
                                 32'h1234_5600, $urandom, $urandom, $urandom));
        issue_access(make_access(OP_STORE, SZ_S16, 8'd7, ZERO_REG, 24'h00000E, $urandom,
                                 32'hFFFF_8001, $urandom, $urandom, $urandom));
        issue_access(load_access(SZ_B64, 8'd2, ZERO_REG, 24'h000008, $urandom));
        // base plus most negative and most positive immediates, and a large base
        issue_access(make_access(OP_STORE, SZ_B32, 8'd9, 8'd5, 24'h800000, 32'h0000_0010,
                                 32'hDEAD_BEEF, $urandom, $urandom, $urandom));
        issue_access(load_access(SZ_B32, 8'd10, 8'd7, 24'h7FFFFF, 32'hFFFF_FFFF));
        issue_access(load_access(SZ_B32, 8'd11, 8'd200, 24'h000010, 32'h8000_0000));
        // error statuses, then valid stores and loads
        issue_access(load_access(SZ_BAD, 8'd3, ZERO_REG, 24'h000000, $urandom));
        issue_access(make_access(OP_STORE, SZ_BAD, 8'd0, 8'd1, 24'($urandom), $urandom,
                                 $urandom, $urandom, $urandom, $urandom));
        issue_access(load_access(SZ_B64, 8'd1, ZERO_REG, 24'h000000, $urandom));
        issue_access(make_access(OP_STORE, SZ_B128, 8'd2, ZERO_REG, 24'h000000, $urandom,
                                 $urandom, $urandom, $urandom, $urandom));
        issue_access(load_access(SZ_B128, 8'd255, ZERO_REG, 24'h000000, $urandom));
        issue_access(make_access(OP_STORE, SZ_B64, 8'd6, ZERO_REG, 24'h000020, $urandom,
                                 32'h0000_0001, 32'hFFFF_FFFE, $urandom, $urandom));
        issue_access(load_access(SZ_B128, 8'd12, ZERO_REG, 24'h000000, $urandom));
        issue_access(make_access(OP_STORE, SZ_U16, 8'd13, ZERO_REG, 24'hFFFFFF, $urandom,
                                 32'h0000_FFFF, $urandom, $urandom, $urandom));
        issue_access(load_access(SZ_U8, 8'd14, ZERO_REG, 24'hFFFFFF, $urandom));
        wait_drained();

        next_drain = n_sent + 500;
        while (n_sent < RANDOM_ITEMS) begin
            repeat ($urandom_range(1, 24))
                issue_access(random_access());
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid = 1'b0;
                repeat ($urandom_range(1, 12))
                    @(negedge i_clk);
            end
            if (n_sent >= next_drain) begin
                wait_drained();
                next_drain += 500;
            end
        end
        wait_drained();
        repeat (8)
            @(negedge i_clk);

        n_written = 0;
        for (k = 0; k < LOCAL_DEPTH; k++)
            n_written += int'(written[k]);
        $display("%0d accesses: %0d loads, %0d stores, %0d invalid size, %0d unaligned",
                 n_sent, n_loads, n_stores, n_bad_size, n_unaligned);
        $display("%0d result beats checked, %0d of %0d local words written",
                 checked, n_written, LOCAL_DEPTH);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: local_memory_load_store_unit.f
+incdir+src
src/llsu_pkg.sv
src/llsu_lane.sv
src/llsu_merge.sv
src/local_memory_load_store_unit.sv
src/llsu_checker.sv
bench/llsu_checker.sv
bench/tb_local_memory_load_store_unit.sv
